// File: design/ste_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table engine package
// Widths, command and status codes, controller states and the control word
// that the controller broadcasts to every cell of the table.
// ----------------------------------------------------------------------------
package ste_pkg;

  // Table depth and the widths that follow from it.
  localparam int DEPTH    = 64;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // Field widths of the words on the two channels.
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int IN_IDX_W = 6;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  // Control word seen by every cell.
  typedef struct packed {
    logic                       compare;
    logic                       update;
    cmd_t                       op;
    logic signed [VALUE_W-1:0]  value;
    logic [CNT_W-1:0]           entry_count;
    logic [IN_IDX_W-1:0]        idx;
    logic                       found;
    logic                       full;
  } cell_ctl_t;

endpackage

// File: design/ste_cell.sv
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one table entry. In the compare cycle it records how its entry
// relates to the command value; in the update cycle it takes the entry of
// its left or right neighbour, or the new value, to open or close a gap.
// ----------------------------------------------------------------------------
module ste_cell (
  input  logic                               clk,
  input  ste_pkg::cell_ctl_t                 ctl,
  input  logic [ste_pkg::CNT_W-1:0]          cell_index,
  input  logic signed [ste_pkg::VALUE_W-1:0] left_entry,
  input  logic signed [ste_pkg::VALUE_W-1:0] right_entry,
  input  logic                               left_after,
  input  logic                               left_match,
  output logic signed [ste_pkg::VALUE_W-1:0] entry,
  output logic                               after,
  output logic                               match,
  output logic                               ins_hot,
  output logic                               eq_hot,
  output logic                               sel
);
  import ste_pkg::*;

  logic at_or_after;
  logic valid;
  logic below_or_at;
  logic before_last;

  // Position of this cell against the current fill level.
  assign valid       = cell_index < ctl.entry_count;
  assign below_or_at = cell_index <= ctl.entry_count;
  assign before_last = (cell_index + CNT_W'(1)) < ctl.entry_count;

  // Flag edges: the first cell past the insertion point and the first equal
  // cell. The after flag is monotone along the sorted row; equal cells form one run.
  assign ins_hot = after & ~left_after;
  assign eq_hot  = match & ~left_match;

  // Compare cycle: record the relation of the entry to the value. Empty
  // cells count as greater so that a new value lands just past the end.
  always_ff @(posedge clk) begin
    if (ctl.compare) begin
      after       <= !valid || (entry > ctl.value);
      match       <= valid && (entry == ctl.value);
      at_or_after <= valid && (entry >= ctl.value);
      sel         <= 32'(cell_index) == 32'(ctl.idx);
    end
  end

  // Update cycle: shift up for insert, shift down for erase.
  always_ff @(posedge clk) begin
    if (ctl.update) begin
      unique case (ctl.op)
        CMD_INSERT: begin
          if (!ctl.full) begin
            if (left_after && below_or_at) begin
              entry <= left_entry;
            end else if (ins_hot) begin
              entry <= ctl.value;
            end
          end
        end
        CMD_ERASE: begin
          if (ctl.found && at_or_after && before_last) begin
            entry <= right_entry;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/ste_encode.sv
// ----------------------------------------------------------------------------
// Sorted table position encoder
// Turns the one-hot edge flags of the cell row into positions and gathers
// the entry selected for a read.
// ----------------------------------------------------------------------------
module ste_encode (
  input  logic [ste_pkg::DEPTH-1:0]          ins_hot,
  input  logic [ste_pkg::DEPTH-1:0]          eq_hot,
  input  logic [ste_pkg::DEPTH-1:0]          sel,
  input  logic signed [ste_pkg::VALUE_W-1:0] entries [ste_pkg::DEPTH],
  output logic [ste_pkg::IDX_W-1:0]          ins_pos,
  output logic [ste_pkg::IDX_W-1:0]          eq_pos,
  output logic                               found,
  output logic signed [ste_pkg::VALUE_W-1:0] rd_data
);
  import ste_pkg::*;

  // At most one flag of each kind is set, so an OR over the row encodes it.
  always_comb begin
    ins_pos = '0;
    eq_pos  = '0;
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ins_hot[i]) ins_pos = ins_pos | IDX_W'(i);
      if (eq_hot[i])  eq_pos  = eq_pos | IDX_W'(i);
      if (sel[i])     rd_data = rd_data | entries[i];
    end
  end

  assign found = |eq_hot;

endmodule

// File: design/sorted_table_engine_top.sv
// ----------------------------------------------------------------------------
// Sorted table engine
// An accepted input word is captured, then compared in the cell row, then
// applied in the update step, which waits while an offered result word has
// not been taken; the result word is then registered and offered. A new
// word is accepted only once the controller is back in its idle state.
// Reset clears the fill count and the handshake state; entries keep their
// contents and are undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_engine_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ste_pkg::CMD_W-1:0]           cmd,
  input  logic signed [ste_pkg::VALUE_W-1:0]  value,
  input  logic [ste_pkg::IN_IDX_W-1:0]        index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ste_pkg::STATUS_W-1:0]        status,
  output logic [ste_pkg::POS_W-1:0]           position,
  output logic signed [ste_pkg::VALUE_W-1:0]  data,
  output logic [ste_pkg::COUNT_W-1:0]         count
);
  import ste_pkg::*;

  state_t                     state, state_next;
  cmd_t                       op;
  logic signed [VALUE_W-1:0]  op_value;
  logic [IN_IDX_W-1:0]        op_idx;
  logic [CNT_W-1:0]           entry_count, entry_count_next;
  logic                       cmp_en, upd_en, out_free;
  cell_ctl_t                  ctl;

  logic signed [VALUE_W-1:0]  cell_entry [DEPTH];
  logic [DEPTH-1:0]           cell_after, cell_match, cell_ins_hot, cell_eq_hot, cell_sel;
  logic [IDX_W-1:0]           ins_pos, eq_pos;
  logic                       found, full, in_range;
  logic signed [VALUE_W-1:0]  rd_data;

  status_t                    status_reg, status_next;
  logic [POS_W-1:0]           position_next;
  logic signed [VALUE_W-1:0]  data_next;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign full     = entry_count == CNT_W'(DEPTH);
  assign in_range = 32'(op_idx) < 32'(entry_count);

  // Controller state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and step strobes.
  always_comb begin
    state_next = state;
    cmp_en     = 1'b0;
    upd_en     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CMP;
      end
      ST_CMP: begin
        cmp_en     = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          upd_en     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture the accepted word.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op       <= cmd_t'(cmd);
      op_value <= value;
      op_idx   <= index;
    end
  end

  // Control word broadcast to the row.
  always_comb begin
    ctl.compare     = cmp_en;
    ctl.update      = upd_en;
    ctl.op          = op;
    ctl.value       = op_value;
    ctl.entry_count = entry_count;
    ctl.idx         = op_idx;
    ctl.found       = found;
    ctl.full        = full;
  end

  // The row of cells; each end sees a neutral neighbour.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_entry, right_entry;
    logic                      left_after, left_match;

    if (i == 0) begin : g_first
      assign left_entry = cell_entry[i];
      assign left_after = 1'b0;
      assign left_match = 1'b0;
    end else begin : g_inner
      assign left_entry = cell_entry[i-1];
      assign left_after = cell_after[i-1];
      assign left_match = cell_match[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_next
      assign right_entry = cell_entry[i+1];
    end

    ste_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_index (CNT_W'(i)),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .left_after (left_after),
      .left_match (left_match),
      .entry      (cell_entry[i]),
      .after      (cell_after[i]),
      .match      (cell_match[i]),
      .ins_hot    (cell_ins_hot[i]),
      .eq_hot     (cell_eq_hot[i]),
      .sel        (cell_sel[i])
    );
  end

  ste_encode u_encode (
    .ins_hot (cell_ins_hot),
    .eq_hot  (cell_eq_hot),
    .sel     (cell_sel),
    .entries (cell_entry),
    .ins_pos (ins_pos),
    .eq_pos  (eq_pos),
    .found   (found),
    .rd_data (rd_data)
  );

  // Result word and new fill level for the command in hand.
  always_comb begin
    status_next      = STAT_OK;
    position_next    = '0;
    data_next        = '0;
    entry_count_next = entry_count;
    unique case (op)
      CMD_INSERT: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          position_next    = POS_W'(ins_pos);
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      CMD_ERASE: begin
        if (found) begin
          position_next    = POS_W'(eq_pos);
          entry_count_next = entry_count - CNT_W'(1);
        end else begin
          status_next = STAT_NOT_FOUND;
        end
      end
      CMD_FIND: begin
        if (found) begin
          position_next = POS_W'(eq_pos);
        end else begin
          status_next = STAT_NOT_FOUND;
        end
      end
      CMD_READ: begin
        if (in_range) begin
          data_next = rd_data;
        end else begin
          status_next = STAT_RANGE;
          data_next   = cell_entry[0];
        end
      end
      default: begin
      end
    endcase
  end

  // Fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (upd_en) begin
      entry_count <= entry_count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      status_reg <= status_next;
      position   <= position_next;
      data       <= data_next;
      count      <= COUNT_W'(entry_count_next);
    end
  end

  assign status = status_reg;

  // The fill level never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(DEPTH))
    else $error("fill level beyond table depth");

  // An accepted word runs through compare and then update.
  a_sequence: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_CMP ##1 state == ST_UPD)
    else $error("controller skipped a step");

  // Every update leaves a result word waiting.
  a_result: assert property (@(posedge clk) disable iff (rst)
    upd_en |=> out_valid)
    else $error("update produced no result word");

  // The fill level moves only on an update.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(upd_en) |-> $stable(entry_count))
    else $error("fill level changed outside an update");

endmodule
